@@ hdl/tiled_texture_pixel_writer_core_assert.svh @@
// Assertion macros shared by the pixel writer RTL.
// Each macro expands to one labelled concurrent assertion; no other dependencies.
`ifndef TILED_TEXTURE_PIXEL_WRITER_CORE_ASSERT_SVH
`define TILED_TEXTURE_PIXEL_WRITER_CORE_ASSERT_SVH

// same-cycle implication
`define TTPW_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error(msg);

// next-cycle implication
`define TTPW_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

@@ hdl/ttpw_pkg.sv @@
// Types and constants for the tiled texture pixel writer.
// No dependencies; used by every module of the block except ttpw_ram.
`timescale 1ns / 1ps

package ttpw_pkg;

	// field widths
	localparam int COORD_W      = 10;
	localparam int BYTE_W       = 8;
	localparam int ADDR_W       = 22;
	localparam int WORD_W       = 16;
	localparam int SURF_W       = 11;
	localparam int DEPTH_W      = 3;
	localparam int CFG_INDEX_W  = 1;
	localparam int S_TDATA_W    = 88;
	localparam int M_TDATA_W    = 40;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_DEPTH  = 1'b1;

	localparam logic [SURF_W-1:0]  SURFACE_WIDTH_RESET = 11'd640;
	localparam logic [DEPTH_W-1:0] SOURCE_DEPTH_RESET  = 3'd2;

	// source depth codes
	localparam logic [DEPTH_W-1:0] DEPTH_PALETTE = 3'd1;
	localparam logic [DEPTH_W-1:0] DEPTH_RGB565  = 3'd2;
	localparam logic [DEPTH_W-1:0] DEPTH_RGB     = 3'd3;
	localparam logic [DEPTH_W-1:0] DEPTH_ARGB    = 3'd4;

	// operation codes (tuser)
	localparam logic OP_PALETTE_WRITE = 1'b0;
	localparam logic OP_PIXEL         = 1'b1;

	localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [ADDR_W-1:0] GB_WORD_OFFSET = 22'd32;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	typedef struct packed {
		logic [SURF_W-1:0]  surface_width;
		logic [DEPTH_W-1:0] source_depth;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data0;
		logic [WORD_W-1:0] data1;
		logic              two;    // RGBA8: second word at addr + 32
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_port_t;

endpackage

@@ hdl/tiled_texture_pixel_writer_core.sv @@
// Top level of the tiled texture pixel writer: configuration registers,
// front end, queue and back end. Depends on ttpw_pkg and all ttpw_* modules.
`timescale 1ns / 1ps

// Usage
//  s_* channel: one request per handshake. tuser = operation (0 palette write,
//    1 pixel). Palette writes store an RGB565 entry and produce nothing.
//  m_* channel: 16-bit texture writes in 4x4-tiled layout, tlast on the final
//    write of a pixel (RGB565: one write; RGBA8: alpha/red, then green/blue
//    32 bytes further on).
//  cfg_we/cfg_index/cfg_data: index 0 surface width, index 1 source depth.
//    Write only while the block is idle.
//  Path: the first write of a pixel passes the front stage (loaded at
//    acceptance), the queue and then the output register.
//  Throughput: one request per cycle while s_tready is high; depths 1
//    and 2 give one pixel per cycle and depths 3 and 4 two words per
//    pixel, as the single output register emits one word per cycle while
//    m_tready is high. Off-surface pixels, unknown depths and palette
//    writes take one input handshake and produce no output.
//  A 4-entry queue separates front and back, so the input keeps flowing
//    while m_tready is low until the queue and front stage fill.
//  Reset: queue empties, outputs go invalid, registers return to width 640
//    and depth 2. Palette contents are undefined until written.
module tiled_texture_pixel_writer_core #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_HEIGHT    = 1024,
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// x, y, src_byte0..3, palette_index, red, green, blue, 4 zero bits
	input  logic [ttpw_pkg::S_TDATA_W-1:0]   s_tdata,
	// operation
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// word_address, word_data, 2 zero bits
	output logic [ttpw_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [ttpw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ttpw_pkg::SURF_W-1:0]      cfg_data
);

	ttpw_pkg::cfg_t    cfg_q;
	ttpw_pkg::q_port_t q_push, q_head;
	logic              q_full, q_pop;

	// config registers: depth takes the low 3 data bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.surface_width <= ttpw_pkg::SURFACE_WIDTH_RESET;
			cfg_q.source_depth  <= ttpw_pkg::SOURCE_DEPTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttpw_pkg::CFG_SURFACE_WIDTH: cfg_q.surface_width <= cfg_data;
				ttpw_pkg::CFG_SOURCE_DEPTH:
					cfg_q.source_depth <= cfg_data[ttpw_pkg::DEPTH_W-1:0];
			endcase
		end
	end

	ttpw_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cfg     (cfg_q),
		.q_full  (q_full),
		.q_push  (q_push)
	);

	ttpw_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.full  (q_full),
		.head  (q_head),
		.pop   (q_pop)
	);

	ttpw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.pop     (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

@@ hdl/ttpw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ttpw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/ttpw_front.sv @@
// Front end: accepts requests, stores palette entries, drops off-surface
// pixels and builds queue entries. Depends on ttpw_pkg and ttpw_ram.
`timescale 1ns / 1ps

module ttpw_front #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_HEIGHT    = 1024,
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ttpw_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	input  ttpw_pkg::cfg_t                 cfg,
	input  logic                           q_full,
	output ttpw_pkg::q_port_t              q_push
);

	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	typedef enum logic [1:0] {
		KIND_PALETTE,
		KIND_RGB565,
		KIND_RGB,
		KIND_ARGB
	} kind_t;

	logic [ttpw_pkg::COORD_W-1:0] x, y;
	logic [ttpw_pkg::BYTE_W-1:0]  b0, b1, b2, b3, pal_idx, red, green, blue;

	assign x       = s_tdata[9:0];
	assign y       = s_tdata[19:10];
	assign b0      = s_tdata[27:20];
	assign b1      = s_tdata[35:28];
	assign b2      = s_tdata[43:36];
	assign b3      = s_tdata[51:44];
	assign pal_idx = s_tdata[59:52];
	assign red     = s_tdata[67:60];
	assign green   = s_tdata[75:68];
	assign blue    = s_tdata[83:76];

	logic  accept, on_surface, depth_known, load_s1;
	kind_t kind;

	logic                          s1_valid_q;
	kind_t                         kind_s1;
	logic [1:0]                    x_lo_s1, y_lo_s1;
	logic [7:0]                    x_tile_s1;
	logic [18:0]                   row_s1;
	logic [ttpw_pkg::BYTE_W-1:0]   b0_s1, b1_s1, b2_s1, b3_s1;
	logic                          idx_ok_s1;
	logic [ttpw_pkg::WORD_W-1:0]   pal_color;

	assign s_tready = !s1_valid_q || !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		depth_known = 1'b1;
		kind        = KIND_RGB565;
		unique case (cfg.source_depth)
			ttpw_pkg::DEPTH_PALETTE: kind = KIND_PALETTE;
			ttpw_pkg::DEPTH_RGB565:  kind = KIND_RGB565;
			ttpw_pkg::DEPTH_RGB:     kind = KIND_RGB;
			ttpw_pkg::DEPTH_ARGB:    kind = KIND_ARGB;
			default:                 depth_known = 1'b0;
		endcase
	end

	assign on_surface = ({1'b0, x} < cfg.surface_width) && (32'(x) < MAX_WIDTH)
		&& (32'(y) < MAX_HEIGHT);
	assign load_s1 = accept && (s_tuser == ttpw_pkg::OP_PIXEL) && on_surface && depth_known;

	// palette: written at acceptance, looked up in the same cycle a pixel enters s1
	ttpw_ram #(
		.WIDTH(ttpw_pkg::WORD_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (accept && (s_tuser == ttpw_pkg::OP_PALETTE_WRITE)
			&& (32'(pal_idx) < PALETTE_DEPTH)),
		.waddr(pal_idx[PAL_AW-1:0]),
		.wdata({red[7:3], green[7:2], blue[7:3]}),
		.re   (load_s1),
		.raddr(b0[PAL_AW-1:0]),
		.rdata(pal_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= load_s1 || (s1_valid_q && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			kind_s1   <= kind;
			x_lo_s1   <= x[1:0];
			y_lo_s1   <= y[1:0];
			x_tile_s1 <= x[9:2];
			row_s1    <= y[9:2] * cfg.surface_width;
			b0_s1     <= b0;
			b1_s1     <= b1;
			b2_s1     <= b2;
			b3_s1     <= b3;
			idx_ok_s1 <= 32'(b0) < PALETTE_DEPTH;
		end
	end

	// tiled address and texel words
	logic [22:0] addr_sum;
	logic [4:0]  inner;
	logic        wide;

	assign inner = {y_lo_s1, x_lo_s1, 1'b0};
	assign wide  = (kind_s1 == KIND_RGB) || (kind_s1 == KIND_ARGB);

	always_comb begin
		if (wide) begin
			addr_sum = {row_s1, 4'b0} + {9'b0, x_tile_s1, 6'b0} + {18'b0, inner};
		end else begin
			addr_sum = {1'b0, row_s1, 3'b0} + {10'b0, x_tile_s1, 5'b0} + {18'b0, inner};
		end
	end

	always_comb begin
		q_push.valid       = s1_valid_q && !q_full;
		q_push.entry.addr  = addr_sum[ttpw_pkg::ADDR_W-1:0];
		q_push.entry.two   = wide;
		q_push.entry.data1 = '0;
		unique case (kind_s1)
			KIND_PALETTE: q_push.entry.data0 = idx_ok_s1 ? pal_color : '0;
			KIND_RGB565:  q_push.entry.data0 = {b0_s1, b1_s1};
			KIND_RGB: begin
				q_push.entry.data0 = {ttpw_pkg::ALPHA_OPAQUE, b0_s1};
				q_push.entry.data1 = {b1_s1, b2_s1};
			end
			KIND_ARGB: begin
				q_push.entry.data0 = {b0_s1, b1_s1};
				q_push.entry.data1 = {b2_s1, b3_s1};
			end
		endcase
	end

endmodule

@@ hdl/ttpw_queue.sv @@
// Short register queue between front and back end.
// Depends on ttpw_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tiled_texture_pixel_writer_core_assert.svh"

module ttpw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  ttpw_pkg::q_port_t push,
	output logic              full,
	output ttpw_pkg::q_port_t head,
	input  logic              pop
);

	ttpw_pkg::q_entry_t mem_q [ttpw_pkg::QUEUE_DEPTH];
	logic [ttpw_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ttpw_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full       = count_q == ttpw_pkg::QUEUE_CNT_W'(ttpw_pkg::QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	`TTPW_ASSERT_IMPL(a_no_push_full, clk, arst_n, push.valid, !full, "push into full queue")
	`TTPW_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, head.valid, "pop from empty queue")

endmodule

@@ hdl/ttpw_back.sv @@
// Back end: turns queue entries into one or two texture word writes
// through the output register. Depends on ttpw_pkg and the macro header.
`timescale 1ns / 1ps
`include "tiled_texture_pixel_writer_core_assert.svh"

module ttpw_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ttpw_pkg::q_port_t              head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ttpw_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);

	logic out_valid_q, out_last_q, phase_q;
	logic [ttpw_pkg::ADDR_W-1:0] out_addr_q;
	logic [ttpw_pkg::WORD_W-1:0] out_data_q;

	logic out_free, load, second;

	assign out_free = !out_valid_q || m_tready;
	assign load     = out_free && head.valid;
	assign second   = head.entry.two && phase_q;
	assign pop      = load && (!head.entry.two || phase_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= head.valid;
			end
			if (load && head.entry.two) begin
				phase_q <= !phase_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_addr_q <= second ? head.entry.addr + ttpw_pkg::GB_WORD_OFFSET : head.entry.addr;
			out_data_q <= second ? head.entry.data1 : head.entry.data0;
			out_last_q <= !head.entry.two || phase_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b0, out_data_q, out_addr_q};

	`TTPW_ASSERT_IMPL(a_phase_head, clk, arst_n, phase_q, head.valid && head.entry.two,
		"second word pending without its entry")
	`TTPW_ASSERT_IMPL(a_first_word, clk, arst_n, out_valid_q && !out_last_q, phase_q,
		"first RGBA8 word shown without second pending")

endmodule

@@ tb/tb_tiled_texture_pixel_writer_core.sv @@
// Self-checking testbench for tiled_texture_pixel_writer_core: a directed table, then random
// phases, checked against typed writes or a built-in texel write predictor.
// Depends on ttpw_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_tiled_texture_pixel_writer_core;

	localparam int MAX_W         = 1024;
	localparam int MAX_H         = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 140;
	localparam int STEADY_PHASE  = 5;        // phase run with no gaps on either side
	localparam int TYPED_NO      = -1;       // row checked by the predictor

	// depth codes with no conversion
	localparam logic [ttpw_pkg::DEPTH_W-1:0] DEPTH_UNUSED_LO = 3'd0;
	localparam logic [ttpw_pkg::DEPTH_W-1:0] DEPTH_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic                          op;
		logic [ttpw_pkg::COORD_W-1:0]  x;
		logic [ttpw_pkg::COORD_W-1:0]  y;
		logic [ttpw_pkg::BYTE_W-1:0]   b0;
		logic [ttpw_pkg::BYTE_W-1:0]   b1;
		logic [ttpw_pkg::BYTE_W-1:0]   b2;
		logic [ttpw_pkg::BYTE_W-1:0]   b3;
		logic [ttpw_pkg::BYTE_W-1:0]   pal_idx;
		logic [ttpw_pkg::BYTE_W-1:0]   red;
		logic [ttpw_pkg::BYTE_W-1:0]   green;
		logic [ttpw_pkg::BYTE_W-1:0]   blue;
	} pixel_req_t;

	typedef struct packed {
		logic [ttpw_pkg::ADDR_W-1:0] addr;
		logic [ttpw_pkg::WORD_W-1:0] data;
		logic                        last;
	} texel_write_t;

	typedef struct {
		bit                                is_cfg;
		logic [ttpw_pkg::CFG_INDEX_W-1:0]  reg_idx;
		logic [ttpw_pkg::SURF_W-1:0]       reg_val;
		pixel_req_t                        req;
		int                                typed;  // TYPED_NO, or number of typed writes
		texel_write_t                      want [2];
	} stim_row_t;

	localparam texel_write_t NO_WRITE = '0;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [ttpw_pkg::S_TDATA_W-1:0]   s_tdata;
	logic                             s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [ttpw_pkg::M_TDATA_W-1:0]   m_tdata;
	logic                             m_tlast;
	logic                             cfg_we;
	logic [ttpw_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ttpw_pkg::SURF_W-1:0]      cfg_data;

	// predictor state: register copies and palette
	logic [ttpw_pkg::SURF_W-1:0]  cur_width;
	logic [ttpw_pkg::DEPTH_W-1:0] cur_depth;
	logic [ttpw_pkg::WORD_W-1:0]  palette_mirror [256];
	bit                           palette_written [256];
	logic [ttpw_pkg::BYTE_W-1:0]  written_entries [$];

	texel_write_t pending_writes [$];
	stim_row_t    directed_rows [$];
	int           mismatches;
	int           cycles;
	bit           no_gaps;

	tiled_texture_pixel_writer_core #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H),
		.PALETTE_DEPTH(256)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// byte offset of texel (x, y); shift 3 for RGB565, 4 for RGBA8
	function automatic logic [ttpw_pkg::ADDR_W-1:0] tile_offset(
			logic [ttpw_pkg::COORD_W-1:0] x, logic [ttpw_pkg::COORD_W-1:0] y,
			logic [ttpw_pkg::SURF_W-1:0] w, int shift);
		int unsigned a;
		a = (32'(y) >> 2) << shift;
		a = a * 32'(w);
		a += (32'(x) >> 2) << (shift + 2);
		a += ((32'(y & 10'd3) << 2) + 32'(x & 10'd3)) << 1;
		return a[ttpw_pkg::ADDR_W-1:0];
	endfunction

	// texel writes caused by one accepted request; palette writes update the mirror
	function automatic int predict_texel_writes(pixel_req_t r, output texel_write_t w [2]);
		logic [ttpw_pkg::ADDR_W-1:0] base;
		w[0] = NO_WRITE;
		w[1] = NO_WRITE;
		if (r.op == ttpw_pkg::OP_PALETTE_WRITE) begin
			palette_mirror[r.pal_idx] = {r.red[7:3], r.green[7:2], r.blue[7:3]};
			if (!palette_written[r.pal_idx]) begin
				palette_written[r.pal_idx] = 1'b1;
				written_entries.push_back(r.pal_idx);
			end
			return 0;
		end
		if (32'(r.x) >= 32'(cur_width) || 32'(r.x) >= MAX_W || 32'(r.y) >= MAX_H)
			return 0;
		case (cur_depth)
			ttpw_pkg::DEPTH_PALETTE: begin
				w[0] = '{tile_offset(r.x, r.y, cur_width, 3), palette_mirror[r.b0], 1'b1};
				return 1;
			end
			ttpw_pkg::DEPTH_RGB565: begin
				w[0] = '{tile_offset(r.x, r.y, cur_width, 3), {r.b0, r.b1}, 1'b1};
				return 1;
			end
			ttpw_pkg::DEPTH_RGB: begin
				base = tile_offset(r.x, r.y, cur_width, 4);
				w[0] = '{base, {ttpw_pkg::ALPHA_OPAQUE, r.b0}, 1'b0};
				w[1] = '{base + ttpw_pkg::GB_WORD_OFFSET, {r.b1, r.b2}, 1'b1};
				return 2;
			end
			ttpw_pkg::DEPTH_ARGB: begin
				base = tile_offset(r.x, r.y, cur_width, 4);
				w[0] = '{base, {r.b0, r.b1}, 1'b0};
				w[1] = '{base + ttpw_pkg::GB_WORD_OFFSET, {r.b2, r.b3}, 1'b1};
				return 2;
			end
			default: return 0;
		endcase
	endfunction

	function automatic pixel_req_t pix(int x, int y, int b0, int b1, int b2, int b3);
		pixel_req_t r;
		r = '0;
		r.op = ttpw_pkg::OP_PIXEL;
		r.x = ttpw_pkg::COORD_W'(x);
		r.y = ttpw_pkg::COORD_W'(y);
		r.b0 = ttpw_pkg::BYTE_W'(b0);
		r.b1 = ttpw_pkg::BYTE_W'(b1);
		r.b2 = ttpw_pkg::BYTE_W'(b2);
		r.b3 = ttpw_pkg::BYTE_W'(b3);
		return r;
	endfunction

	function automatic pixel_req_t pal(int idx, int red, int green, int blue);
		pixel_req_t r;
		r = '0;
		r.op = ttpw_pkg::OP_PALETTE_WRITE;
		r.pal_idx = ttpw_pkg::BYTE_W'(idx);
		r.red = ttpw_pkg::BYTE_W'(red);
		r.green = ttpw_pkg::BYTE_W'(green);
		r.blue = ttpw_pkg::BYTE_W'(blue);
		return r;
	endfunction

	function automatic texel_write_t wr(int addr, int data, bit last);
		texel_write_t t;
		t.addr = ttpw_pkg::ADDR_W'(addr);
		t.data = ttpw_pkg::WORD_W'(data);
		t.last = last;
		return t;
	endfunction

	function automatic void row_item(pixel_req_t r, int typed, texel_write_t w0,
			texel_write_t w1);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.req = r;
		row.typed = typed;
		row.want[0] = w0;
		row.want[1] = w1;
		directed_rows.push_back(row);
	endfunction

	function automatic void row_cfg(logic [ttpw_pkg::CFG_INDEX_W-1:0] idx, int val);
		stim_row_t row;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = ttpw_pkg::SURF_W'(val);
		row.req = '0;
		row.typed = 0;
		row.want[0] = NO_WRITE;
		row.want[1] = NO_WRITE;
		directed_rows.push_back(row);
	endfunction

	// mostly in-surface pixels; depth-one lookups only hit written entries
	function automatic pixel_req_t random_request();
		logic [95:0] bits;
		pixel_req_t  r;
		int          roll;
		int          x_top;
		bits = {$urandom(), $urandom(), $urandom()};
		r = bits[$bits(pixel_req_t)-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 20 || (cur_depth == ttpw_pkg::DEPTH_PALETTE
				&& written_entries.size() == 0)) begin
			r.op = ttpw_pkg::OP_PALETTE_WRITE;
		end else begin
			r.op = ttpw_pkg::OP_PIXEL;
			x_top = (cur_width > MAX_W) ? MAX_W - 1 : int'(cur_width) - 1;
			if (roll < 90 && cur_width != 0)
				r.x = ttpw_pkg::COORD_W'($urandom_range(0, x_top));
			if (cur_depth == ttpw_pkg::DEPTH_PALETTE)
				r.b0 = written_entries[$urandom_range(0, written_entries.size() - 1)];
		end
		return r;
	endfunction

	// configuration is only touched with the block drained
	task automatic write_register(logic [ttpw_pkg::CFG_INDEX_W-1:0] idx,
			logic [ttpw_pkg::SURF_W-1:0] val);
		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ttpw_pkg::CFG_SURFACE_WIDTH)
			cur_width = val;
		else
			cur_depth = val[ttpw_pkg::DEPTH_W-1:0];
	endtask

	task automatic maybe_pause();
		if (!no_gaps && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// holds the request until accepted; valid stays high for a following request
	task automatic offer_request(pixel_req_t r);
		s_tdata <= {4'b0, r.blue, r.green, r.red, r.pal_idx, r.b3, r.b2, r.b1, r.b0,
			r.y, r.x};
		s_tuser <= r.op;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic log_mismatch(string what, texel_write_t want, texel_write_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected addr %h data %h last %b, got addr %h data %h last %b",
				$realtime, what, want.addr, want.data, want.last, got.addr, got.data,
				got.last);
	endtask

	// sink side: random back-pressure
	always @(posedge clk)
		m_tready <= no_gaps || ($urandom_range(0, 99) >= 10);

	always @(posedge clk) begin : check_writes
		texel_write_t want;
		texel_write_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[ttpw_pkg::ADDR_W-1:0],
				m_tdata[ttpw_pkg::ADDR_W +: ttpw_pkg::WORD_W], m_tlast};
			if (pending_writes.size() == 0) begin
				log_mismatch("unexpected write", NO_WRITE, got);
			end else begin
				want = pending_writes.pop_front();
				if (got != want)
					log_mismatch("write mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		texel_write_t predicted [2];
		pixel_req_t   r;
		int           n;
		int           counted;
		int           w;
		int           d;

		mismatches = 0;
		cycles = 0;
		no_gaps = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cur_width = ttpw_pkg::SURFACE_WIDTH_RESET;
		cur_depth = ttpw_pkg::SOURCE_DEPTH_RESET;
		for (int i = 0; i < 256; i++) begin
			palette_mirror[i] = '0;
			palette_written[i] = 1'b0;
		end

		// directed table; reset leaves width 640, depth RGB565
		row_item(pix(0, 0, 'h12, 'h34, 0, 0), 1, wr(0, 'h1234, 1), NO_WRITE);
		row_item(pix(639, 1023, 'hff, 'hff, 'hff, 'hff), 1, wr(1310718, 'hffff, 1),
			NO_WRITE);
		row_item(pix(640, 5, 'h55, 'haa, 0, 0), 0, NO_WRITE, NO_WRITE);  // x == width
		row_item(pal(0, 'hff, 'hff, 'hff), 0, NO_WRITE, NO_WRITE);
		row_item(pal(255, 'h08, 'h04, 'h08), 0, NO_WRITE, NO_WRITE);
		row_item(pal('h5a, 'hf8, 'h00, 'h00), 0, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::DEPTH_PALETTE);
		row_item(pix(1, 2, 0, 0, 0, 0), 1, wr(18, 'hffff, 1), NO_WRITE);
		row_item(pix(5, 5, 255, 0, 0, 0), 1, wr(5162, 'h0821, 1), NO_WRITE);
		row_item(pix(100, 200, 'h5a, 1, 2, 3), TYPED_NO, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::DEPTH_RGB);
		row_item(pix(0, 0, 'h11, 'h22, 'h33, 'h44), 2, wr(0, 'hff11, 0), wr(32, 'h2233, 1));
		row_item(pix(1023, 1023, 1, 2, 3, 4), 0, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::DEPTH_ARGB);
		row_item(pix(3, 3, 'hde, 'had, 'hbe, 'hef), 2, wr(30, 'hdead, 0), wr(62, 'hbeef, 1));
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, DEPTH_UNUSED_LO);
		row_item(pix(0, 0, 1, 2, 3, 4), 0, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, DEPTH_UNUSED_HI);
		row_item(pix(1, 1, 1, 2, 3, 4), 0, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SURFACE_WIDTH, 1024);
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::DEPTH_ARGB);
		row_item(pix(1023, 1023, 'hff, 'hff, 'hff, 'hff), 2, wr(4194270, 'hffff, 0),
			wr(4194302, 'hffff, 1));
		row_item(pix(0, 1023, 0, 0, 0, 0), TYPED_NO, NO_WRITE, NO_WRITE);
		// wide surface: address wraps at 22 bits
		row_cfg(ttpw_pkg::CFG_SURFACE_WIDTH, 2047);
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::DEPTH_RGB);
		row_item(pix(1023, 1023, 'h80, 'h7f, 'h01, 0), TYPED_NO, NO_WRITE, NO_WRITE);
		row_item(pix(1000, 517, 'h3c, 'hc3, 'h99, 0), TYPED_NO, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SURFACE_WIDTH, 13);  // odd width used as is
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::DEPTH_RGB565);
		row_item(pix(12, 7, 'hab, 'hcd, 0, 0), TYPED_NO, NO_WRITE, NO_WRITE);
		row_item(pix(13, 0, 'hab, 'hcd, 0, 0), 0, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SURFACE_WIDTH, 0);
		row_item(pix(0, 0, 1, 1, 1, 1), 0, NO_WRITE, NO_WRITE);
		row_cfg(ttpw_pkg::CFG_SURFACE_WIDTH, 4);
		row_cfg(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::DEPTH_PALETTE);
		row_item(pix(3, 1023, 255, 0, 0, 0), TYPED_NO, NO_WRITE, NO_WRITE);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				maybe_pause();
				offer_request(directed_rows[i].req);
				n = predict_texel_writes(directed_rows[i].req, predicted);
				if (directed_rows[i].typed != TYPED_NO) begin
					n = directed_rows[i].typed;
					predicted = directed_rows[i].want;
				end
				for (int k = 0; k < n; k++)
					pending_writes.push_back(predicted[k]);
			end
		end

		// random phases: extremes first, then random settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin w = 640;  d = ttpw_pkg::DEPTH_PALETTE; end
				1: begin w = 4;    d = ttpw_pkg::DEPTH_RGB565;  end
				2: begin w = 1024; d = ttpw_pkg::DEPTH_RGB;     end
				3: begin w = 1024; d = ttpw_pkg::DEPTH_ARGB;    end
				4: begin w = 2047; d = ttpw_pkg::DEPTH_ARGB;    end
				5: begin w = 1024; d = ttpw_pkg::DEPTH_PALETTE; end
				6: begin w = 13;   d = ttpw_pkg::DEPTH_RGB;     end
				7: begin w = 1;    d = ttpw_pkg::DEPTH_RGB565;  end
				default: begin
					w = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 256) * 4
						: $urandom_range(0, 2047);
					d = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
						: $urandom_range(0, 7);
				end
			endcase
			write_register(ttpw_pkg::CFG_SURFACE_WIDTH, ttpw_pkg::SURF_W'(w));
			write_register(ttpw_pkg::CFG_SOURCE_DEPTH, ttpw_pkg::SURF_W'(d));
			no_gaps = (p == STEADY_PHASE);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				maybe_pause();
				r = random_request();
				offer_request(r);
				n = predict_texel_writes(r, predicted);
				for (int k = 0; k < n; k++)
					pending_writes.push_back(predicted[k]);
				counted++;
			end
			no_gaps = 1'b0;
		end

		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += pending_writes.size();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ttpw_pkg.sv
hdl/ttpw_ram.sv
hdl/ttpw_front.sv
hdl/ttpw_queue.sv
hdl/ttpw_back.sv
hdl/tiled_texture_pixel_writer_core.sv
tb/tb_tiled_texture_pixel_writer_core.sv
